// ===== src/nds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nds_pkg: shared types and constants of the nearest-neighbor downscaler
// Field widths, 12.16 accumulator layout, register indexes and the structs
// passed between the configuration, scan and top-level modules.
// ----------------------------------------------------------------------------
package nds_pkg;

  // Field and state widths
  localparam int CFG_W    = 12;   // size registers
  localparam int CNT_W    = 11;   // source column / row counters
  localparam int ACC_W    = 28;   // 12.16 target accumulators, wrapping
  localparam int FRAC_W   = 16;   // fractional bits of the accumulators
  localparam int PIX_W    = 16;   // RGB565 word
  localparam int CHAN_W   = 8;    // expanded channel
  localparam int COORD_W  = 8;    // output coordinate fields
  localparam int CFG_IDX_W = 1;

  // Counters end the row / frame at this value, a row / frame never runs longer
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Reset sizes of the source image
  localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 12'd320;
  localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 12'd240;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } cfg_reg_t;

  // Sizes and derived steps handed to the scan logic
  typedef struct packed {
    logic [CFG_W-1:0] src_width;
    logic [CFG_W-1:0] src_height;
    logic [ACC_W-1:0] xstep;
    logic [ACC_W-1:0] ystep;
  } step_cfg_t;

  // Pick decision for the word being processed
  typedef struct packed {
    logic               hit;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               done;
  } scan_res_t;

  // Expanded RGB888 pixel
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb888_t;

  // Undo the camera byte swap, split RGB565 and widen by bit replication
  function automatic rgb888_t expand_rgb565(input logic [PIX_W-1:0] word);
    logic [PIX_W-1:0] pix;
    rgb888_t          res;
    pix       = {word[7:0], word[15:8]};
    res.red   = {pix[15:11], pix[15:13]};
    res.green = {pix[10:5], pix[10:9]};
    res.blue  = {pix[4:0], pix[4:2]};
    return res;
  endfunction

endpackage

// ===== src/nds_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nds_cfg: size registers and scaling steps
// Holds source width and height. On a write the step
// (size << 16) / OUT + 1 is formed by a constant reciprocal multiply and
// stored, so the scan logic sees a ready step in the next cycle.
// ----------------------------------------------------------------------------
module nds_cfg #(
  parameter int OUT_WIDTH  = 224,
  parameter int OUT_HEIGHT = 224
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [nds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nds_pkg::CFG_W-1:0]      cfg_wdata,
  output nds_pkg::step_cfg_t             step_cfg
);
  import nds_pkg::*;

  // Exact floor division of a 28-bit dividend: m = ceil(2^(28+l) / d),
  // quotient = (N * m) >> (28 + l), with l = ceil(log2 d). The dividend is
  // size << 16, so the low 16 bits of the shift are folded away.
  localparam int XL      = $clog2(OUT_WIDTH);
  localparam int YL      = $clog2(OUT_HEIGHT);
  localparam int MUL_W   = ACC_W + 1;
  localparam int PROD_W  = CFG_W + MUL_W;
  localparam int XSHIFT  = ACC_W + XL - FRAC_W;
  localparam int YSHIFT  = ACC_W + YL - FRAC_W;
  localparam logic [63:0] XMUL_FULL =
    ((64'd1 << (ACC_W + XL)) + 64'(OUT_WIDTH) - 64'd1) / 64'(OUT_WIDTH);
  localparam logic [63:0] YMUL_FULL =
    ((64'd1 << (ACC_W + YL)) + 64'(OUT_HEIGHT) - 64'd1) / 64'(OUT_HEIGHT);
  localparam logic [MUL_W-1:0] XMUL = XMUL_FULL[MUL_W-1:0];
  localparam logic [MUL_W-1:0] YMUL = YMUL_FULL[MUL_W-1:0];

  // Steps for the reset sizes
  localparam logic [63:0] XSTEP_RST_FULL =
    ((64'(SRC_WIDTH_RST) << FRAC_W) / 64'(OUT_WIDTH)) + 64'd1;
  localparam logic [63:0] YSTEP_RST_FULL =
    ((64'(SRC_HEIGHT_RST) << FRAC_W) / 64'(OUT_HEIGHT)) + 64'd1;

  logic [CFG_W-1:0]  src_width_r,  src_width_nxt;
  logic [CFG_W-1:0]  src_height_r, src_height_nxt;
  logic [ACC_W-1:0]  xstep_r,      xstep_nxt;
  logic [ACC_W-1:0]  ystep_r,      ystep_nxt;
  logic [PROD_W-1:0] xprod, yprod;

  // Reciprocal products of the write data
  assign xprod = PROD_W'(cfg_wdata) * PROD_W'(XMUL);
  assign yprod = PROD_W'(cfg_wdata) * PROD_W'(YMUL);

  // Register write decode
  always_comb begin
    src_width_nxt  = src_width_r;
    src_height_nxt = src_height_r;
    xstep_nxt      = xstep_r;
    ystep_nxt      = ystep_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH: begin
          src_width_nxt = cfg_wdata;
          xstep_nxt     = ACC_W'(xprod >> XSHIFT) + ACC_W'(1);
        end
        REG_SRC_HEIGHT: begin
          src_height_nxt = cfg_wdata;
          ystep_nxt      = ACC_W'(yprod >> YSHIFT) + ACC_W'(1);
        end
        default: begin
          src_width_nxt = src_width_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
      xstep_r      <= XSTEP_RST_FULL[ACC_W-1:0];
      ystep_r      <= YSTEP_RST_FULL[ACC_W-1:0];
    end else begin
      src_width_r  <= src_width_nxt;
      src_height_r <= src_height_nxt;
      xstep_r      <= xstep_nxt;
      ystep_r      <= ystep_nxt;
    end
  end

  assign step_cfg.src_width  = src_width_r;
  assign step_cfg.src_height = src_height_r;
  assign step_cfg.xstep      = xstep_r;
  assign step_cfg.ystep      = ystep_r;

endmodule

// ===== src/nds_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nds_scan: raster position and nearest-neighbor pick
// Tracks source column/row, next output column/row and the 12.16 targets.
// Decides per word whether it is the pick for the next output position and
// advances the state when a word is processed.
// ----------------------------------------------------------------------------
module nds_scan #(
  parameter int OUT_WIDTH  = 224,
  parameter int OUT_HEIGHT = 224
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               proc_en,
  input  logic               frame_start,
  input  nds_pkg::step_cfg_t step_cfg,
  output nds_pkg::scan_res_t scan_res
);
  import nds_pkg::*;

  localparam int OCOL_W = $clog2(OUT_WIDTH + 1);
  localparam int OROW_W = $clog2(OUT_HEIGHT + 1);
  localparam int INT_W  = ACC_W - FRAC_W;

  logic [CNT_W-1:0]  src_col_r, src_col_nxt;
  logic [CNT_W-1:0]  src_row_r, src_row_nxt;
  logic [OCOL_W-1:0] ocol_r,    ocol_nxt;
  logic [OROW_W-1:0] orow_r,    orow_nxt;
  logic [ACC_W-1:0]  cacc_r,    cacc_nxt;
  logic [ACC_W-1:0]  racc_r,    racc_nxt;

  // State as seen by this word (cleared at frame start)
  logic [CNT_W-1:0]  col_c, row_c;
  logic [OCOL_W-1:0] ocol_c;
  logic [OROW_W-1:0] orow_c;
  logic [ACC_W-1:0]  cacc_c, racc_c;
  logic              row_hit, col_hit, hit, row_end, frame_end;

  assign col_c  = frame_start ? '0 : src_col_r;
  assign row_c  = frame_start ? '0 : src_row_r;
  assign ocol_c = frame_start ? '0 : ocol_r;
  assign orow_c = frame_start ? '0 : orow_r;
  assign cacc_c = frame_start ? '0 : cacc_r;
  assign racc_c = frame_start ? '0 : racc_r;

  // Pick test: integer part of each target meets the source position, output not full
  assign row_hit = (racc_c[ACC_W-1:FRAC_W] == INT_W'(row_c)) &&
                   (orow_c < OROW_W'(OUT_HEIGHT));
  assign col_hit = (cacc_c[ACC_W-1:FRAC_W] == INT_W'(col_c)) &&
                   (ocol_c < OCOL_W'(OUT_WIDTH));
  assign hit     = row_hit && col_hit;

  // Row and frame boundaries
  assign row_end   = ((CFG_W'(col_c) + CFG_W'(1)) >= step_cfg.src_width) ||
                     (col_c == CNT_MAX);
  assign frame_end = ((CFG_W'(row_c) + CFG_W'(1)) >= step_cfg.src_height) ||
                     (row_c == CNT_MAX);

  // Next state
  always_comb begin
    src_col_nxt = col_c + CNT_W'(1);
    src_row_nxt = row_c;
    ocol_nxt    = hit ? ocol_c + OCOL_W'(1) : ocol_c;
    orow_nxt    = orow_c;
    cacc_nxt    = hit ? cacc_c + step_cfg.xstep : cacc_c;
    racc_nxt    = racc_c;
    if (row_end) begin
      src_col_nxt = '0;
      ocol_nxt    = '0;
      cacc_nxt    = '0;
      priority if (frame_end) begin
        src_row_nxt = '0;
        orow_nxt    = '0;
        racc_nxt    = '0;
      end else if (row_hit) begin
        src_row_nxt = row_c + CNT_W'(1);
        orow_nxt    = orow_c + OROW_W'(1);
        racc_nxt    = racc_c + step_cfg.ystep;
      end else begin
        src_row_nxt = row_c + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      src_row_r <= '0;
      ocol_r    <= '0;
      orow_r    <= '0;
      cacc_r    <= '0;
      racc_r    <= '0;
    end else if (proc_en) begin
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      ocol_r    <= ocol_nxt;
      orow_r    <= orow_nxt;
      cacc_r    <= cacc_nxt;
      racc_r    <= racc_nxt;
    end
  end

  assign scan_res.hit    = hit;
  assign scan_res.column = COORD_W'(ocol_c);
  assign scan_res.row    = COORD_W'(orow_c);
  assign scan_res.done   = (ocol_c == OCOL_W'(OUT_WIDTH - 1)) &&
                           (orow_c == OROW_W'(OUT_HEIGHT - 1));

endmodule

// ===== src/nearest_downscale_rgb565_to_rgb888_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_downscale_rgb565_to_rgb888_top: streaming nearest-neighbor scaler
// Source RGB565 words (byte swapped) enter in raster order on the in_ channel,
// in_frame_start marking the first word of a frame. Words picked for the
// OUT_WIDTH x OUT_HEIGHT output grid leave on the out_ channel as RGB888 with
// their output column/row; out_frame_done flags the last output pixel.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. One word is accepted per cycle while in_stall is low; a picked
// word passes the input register, then the result register, to the output.
// Words that are not picked produce nothing.
// The result register parts the two sides: while a result waits under
// out_stall, one more word is taken into the input register, after which
// in_stall rises until the result is taken.
// cfg_we/cfg_index/cfg_wdata write source width (index 0) and height
// (index 1); the new step is usable from the next cycle. Write only while
// the stream is idle.
// Synchronous reset restores 320 x 240, clears scan state and empties both
// registers.
// ----------------------------------------------------------------------------
module nearest_downscale_rgb565_to_rgb888_top #(
  parameter int OUT_WIDTH  = 224,
  parameter int OUT_HEIGHT = 224
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [nds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nds_pkg::CFG_W-1:0]      cfg_wdata,
  // source words
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [nds_pkg::PIX_W-1:0]      in_pixel_word,
  input  logic                           in_frame_start,
  // output pixels
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [nds_pkg::CHAN_W-1:0]     out_red,
  output logic [nds_pkg::CHAN_W-1:0]     out_green,
  output logic [nds_pkg::CHAN_W-1:0]     out_blue,
  output logic [nds_pkg::COORD_W-1:0]    out_column,
  output logic [nds_pkg::COORD_W-1:0]    out_row,
  output logic                           out_frame_done
);
  import nds_pkg::*;

  step_cfg_t         step_cfg;
  scan_res_t         scan_res;
  rgb888_t           rgb;

  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic              s1_fs_r;
  logic              adv, proc_en, in_acc;

  logic              out_valid_r;
  rgb888_t           out_rgb_r;
  logic [COORD_W-1:0] out_col_r, out_row_r;
  logic              out_done_r;

  // Result register free or draining this cycle
  assign adv      = !out_valid_r || !out_stall;
  assign proc_en  = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  nds_cfg #(
    .OUT_WIDTH (OUT_WIDTH),
    .OUT_HEIGHT(OUT_HEIGHT)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .step_cfg (step_cfg)
  );

  nds_scan #(
    .OUT_WIDTH (OUT_WIDTH),
    .OUT_HEIGHT(OUT_HEIGHT)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .proc_en    (proc_en),
    .frame_start(s1_fs_r),
    .step_cfg   (step_cfg),
    .scan_res   (scan_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r <= in_pixel_word;
      s1_fs_r  <= in_frame_start;
    end
  end

  assign rgb = expand_rgb565(s1_pix_r);

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= proc_en && scan_res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en && scan_res.hit) begin
      out_rgb_r  <= rgb;
      out_col_r  <= scan_res.column;
      out_row_r  <= scan_res.row;
      out_done_r <= scan_res.done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_rgb_r.red;
  assign out_green      = out_rgb_r.green;
  assign out_blue       = out_rgb_r.blue;
  assign out_column     = out_col_r;
  assign out_row        = out_row_r;
  assign out_frame_done = out_done_r;

endmodule

// ===== src/nds_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nds_check: port-level checks of the downscaler
// Watches the channel ports of the top level and flags broken flow control
// or inconsistent output coordinates.
// ----------------------------------------------------------------------------
module nds_check #(
  parameter int OUT_WIDTH  = 224,
  parameter int OUT_HEIGHT = 224
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [nds_pkg::CHAN_W-1:0]  out_red,
  input logic [nds_pkg::CHAN_W-1:0]  out_green,
  input logic [nds_pkg::CHAN_W-1:0]  out_blue,
  input logic [nds_pkg::COORD_W-1:0] out_column,
  input logic [nds_pkg::COORD_W-1:0] out_row,
  input logic                        out_frame_done
);
  import nds_pkg::*;

  localparam logic [COORD_W-1:0] LAST_COL = COORD_W'(OUT_WIDTH - 1);
  localparam logic [COORD_W-1:0] LAST_ROW = COORD_W'(OUT_HEIGHT - 1);

  // A stalled output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) &&
      $stable(out_green) && $stable(out_blue) && $stable(out_column) &&
      $stable(out_row) && $stable(out_frame_done))
    else $error("stalled output word changed");

  // Input backs up only behind a held output word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled output");

  // Frame done only on the last output position
  a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_column == LAST_COL && out_row == LAST_ROW)
    else $error("frame_done off the last output position");

  // Reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind nearest_downscale_rgb565_to_rgb888_top nds_check #(
  .OUT_WIDTH (OUT_WIDTH),
  .OUT_HEIGHT(OUT_HEIGHT)
) u_nds_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue),
  .out_column    (out_column),
  .out_row       (out_row),
  .out_frame_done(out_frame_done)
);
